[design/cbta_pkg.sv]
package cbta_pkg;

  localparam int TableCountDefault  = 4;
  localparam int SectorBytesDefault = 32;
  localparam int RootTableDefault   = 0;
  localparam int RootEntryDefault   = 1;

  localparam logic [7:0] MarkFree   = 8'd0;
  localparam logic [7:0] MarkEnd    = 8'd255;
  localparam int         MaxSectors = 254;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusTooLong = 2'd1,
    StatusNoRoom  = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture the request fields
    logic clr_step;  // write one clearing entry at the sweep address
    logic pick_step; // compare one free count for the emptiest table
    logic rd;        // issue link read at the current address
    logic alloc_hit; // link the entry read last into the chain
    logic alloc_adv; // step to the next entry
    logic free_hit;  // clear the entry and follow its link
    logic commit;    // update the free count
    logic emit;      // drive the result beat
  } cbta_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic pick_done;
    logic is_free;     // request is a free
    logic too_long;
    logic no_room;
    logic bad_table;
    logic rd_is_free;  // entry read is marked free
    logic alloc_done;  // all entries linked or scan at the end
    logic free_stop;   // free walk must stop
  } cbta_stat_t;

endpackage

[design/chained_block_table_allocator.sv]
// Allocate: each table entry scanned passes S_RD, S_WAIT, S_EVAL and S_OUT, then
// S_COMMIT and S_EMIT lead to done; S_PICK comes first when picking the emptiest
// table, and a rejected allocate goes from S_CHECK to S_EMIT. Free: each chain entry
// cleared passes the same states; the scan is set by the single link-table read port.
// Throughput: one request at a time; start is taken only while busy is low.
// Reset: synchronous; a clearing pass over all TABLE_COUNT*256 entries formats the tables,
// busy stays high throughout. Results appear for one cycle on done; no stall.
module chained_block_table_allocator #(
  parameter int TABLE_COUNT  = cbta_pkg::TableCountDefault,
  parameter int SECTOR_BYTES = cbta_pkg::SectorBytesDefault,
  parameter int ROOT_TABLE   = cbta_pkg::RootTableDefault,
  parameter int ROOT_ENTRY   = cbta_pkg::RootEntryDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic        mode,
  input  logic [15:0] length,
  input  logic        use_emptiest,
  input  logic [1:0]  target_table,
  input  logic [7:0]  start_entry,
  output logic [1:0]  status,
  output logic [1:0]  table_id,
  output logic [7:0]  first_entry,
  output logic [5:0]  tail_bytes,
  output logic [7:0]  entries_moved,
  output logic [7:0]  free_left
);
  import cbta_pkg::*;

  cbta_cmd_t  cmd;
  cbta_stat_t stat;

  cbta_ctrl u_ctrl (
    .clk, .rst, .start, .use_emptiest, .mode, .busy, .done, .cmd, .stat
  );

  cbta_datapath #(
    .TABLE_COUNT(TABLE_COUNT), .SECTOR_BYTES(SECTOR_BYTES),
    .ROOT_TABLE(ROOT_TABLE), .ROOT_ENTRY(ROOT_ENTRY)
  ) u_dp (
    .clk, .rst, .cmd, .stat, .mode, .length, .use_emptiest, .target_table,
    .start_entry, .status, .table_id, .first_entry, .tail_bytes,
    .entries_moved, .free_left
  );

endmodule

[design/cbta_datapath.sv]
module cbta_datapath #(
  parameter int TABLE_COUNT  = cbta_pkg::TableCountDefault,
  parameter int SECTOR_BYTES = cbta_pkg::SectorBytesDefault,
  parameter int ROOT_TABLE   = cbta_pkg::RootTableDefault,
  parameter int ROOT_ENTRY   = cbta_pkg::RootEntryDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cbta_pkg::cbta_cmd_t   cmd,
  output cbta_pkg::cbta_stat_t  stat,
  input  logic                  mode,
  input  logic [15:0]           length,
  input  logic                  use_emptiest,
  input  logic [1:0]            target_table,
  input  logic [7:0]            start_entry,
  output logic [1:0]            status,
  output logic [1:0]            table_id,
  output logic [7:0]            first_entry,
  output logic [5:0]            tail_bytes,
  output logic [7:0]            entries_moved,
  output logic [7:0]            free_left
);
  import cbta_pkg::*;

  localparam int TW    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int RW    = (TW > 2) ? TW : 2;
  localparam int TCW   = $clog2(TABLE_COUNT + 1);
  localparam int AW    = TW + 8;
  localparam int DEPTH = TABLE_COUNT * 256;
  localparam int SBW   = $clog2(SECTOR_BYTES + 1);
  localparam int RootOk = (ROOT_TABLE < TABLE_COUNT) ? 1 : 0;

  logic [7:0]     mem [DEPTH];
  logic [7:0]     rd_data;
  logic [AW-1:0]  clr_addr;
  logic [7:0]     counts [TABLE_COUNT];

  logic           r_mode;
  logic [RW-1:0]  r_table;
  logic [TW-1:0]  tsel;
  logic           bad;
  logic [16:0]    sectors;
  logic [SBW-1:0] tail;
  logic [8:0]     need;
  logic [7:0]     cur;
  logic [7:0]     prev;
  logic [7:0]     first;
  logic [7:0]     done;
  logic [TCW-1:0] pick_i;
  logic [TW-1:0]  best;
  logic           waddr_en;
  logic [AW-1:0]  waddr;
  logic [7:0]     wdata;

  logic [16:0]    sect_c;
  logic [SBW-1:0] tail_c;
  logic [AW-1:0]  cur_addr;

  // split length into sectors and tail
  always_comb begin
    sect_c = 17'(length / SECTOR_BYTES);
    tail_c = SBW'(length % SECTOR_BYTES);
    if (tail_c == '0 && sect_c != '0) tail_c = SBW'(SECTOR_BYTES);
  end

  assign tsel     = TW'(r_table);
  assign cur_addr = {tsel, cur};

  // memory write selection: clear sweep, link or unlink
  always_comb begin
    waddr_en = 1'b0;
    waddr    = cur_addr;
    wdata    = MarkFree;
    if (cmd.clr_step) begin
      waddr_en = 1'b1;
      waddr    = clr_addr;
      wdata    = (RootOk == 1 && clr_addr == AW'(ROOT_TABLE * 256 + ROOT_ENTRY))
                 ? MarkEnd : MarkFree;
    end else if (cmd.alloc_hit) begin
      waddr_en = 1'b1;
      wdata    = MarkEnd;
    end else if (cmd.free_hit) begin
      waddr_en = 1'b1;
      wdata    = MarkFree;
    end
  end

  // link table memory, two write paths and one registered read
  always_ff @(posedge clk) begin
    if (waddr_en) mem[waddr] <= wdata;
    if (cmd.alloc_hit && done != 8'd0) mem[{tsel, prev}] <= cur;
    if (cmd.rd) rd_data <= mem[cur_addr];
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr_step) clr_addr <= clr_addr + 1'b1;
  end

  // request registers and walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < TABLE_COUNT; t++)
        counts[t] <= (RootOk == 1 && t == ROOT_TABLE) ? 8'd253 : 8'd254;
      pick_i <= '0;
    end else begin
      if (cmd.load) begin
        r_mode  <= mode;
        r_table <= (use_emptiest && !mode) ? '0 : RW'(target_table);
        sectors <= sect_c;
        tail    <= tail_c;
        need    <= 9'(sect_c) + 9'd1 - ((tail_c == SBW'(SECTOR_BYTES)) ? 9'd1 : 9'd0);
        cur     <= mode ? start_entry : 8'd1;
        first   <= 8'd0;
        done    <= 8'd0;
        pick_i  <= TCW'(1);
        best    <= '0;
      end
      if (cmd.pick_step) begin
        if (counts[pick_i[TW-1:0]] > counts[best]) best <= pick_i[TW-1:0];
        pick_i <= pick_i + 1'b1;
      end
      if (cmd.pick_step && pick_i == TCW'(TABLE_COUNT - 1))
        r_table <= RW'((counts[pick_i[TW-1:0]] > counts[best]) ? pick_i[TW-1:0] : best);
      if (cmd.alloc_hit) begin
        if (done == 8'd0) first <= cur;
        prev <= cur;
        done <= done + 8'd1;
      end
      if (cmd.alloc_adv) cur <= cur + 8'd1;
      if (cmd.free_hit) begin
        cur  <= rd_data;
        done <= done + 8'd1;
      end
      if (cmd.commit) begin
        if (r_mode) counts[tsel] <= counts[tsel] + done;
        else        counts[tsel] <= counts[tsel] - done;
      end
    end
  end

  assign bad = (int'(r_table) >= TABLE_COUNT);

  always_comb begin
    stat            = '0;
    stat.clr_done   = (clr_addr == AW'(DEPTH - 1));
    stat.pick_done  = (pick_i >= TCW'(TABLE_COUNT - 1));
    stat.is_free    = r_mode;
    stat.too_long   = (sectors > 17'(MaxSectors));
    stat.bad_table  = bad;
    stat.no_room    = bad || (need > {1'b0, counts[tsel]});
    stat.rd_is_free = (rd_data == MarkFree);
    stat.alloc_done = (9'(done) >= need) || (cur == 8'd255);
    stat.free_stop  = bad || cur == MarkFree || cur == MarkEnd || done >= 8'd254;
  end

  // result beat registers
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      table_id      <= r_table[1:0];
      free_left     <= bad ? 8'd0 : counts[tsel];
      first_entry   <= 8'd0;
      tail_bytes    <= 6'd0;
      entries_moved <= 8'd0;
      if (r_mode) begin
        status        <= StatusOk;
        entries_moved <= done;
      end else if (sectors > 17'(MaxSectors)) begin
        status <= StatusTooLong;
      end else if (bad || (need > {1'b0, counts[tsel]} && done == 8'd0)) begin
        status <= StatusNoRoom;
      end else begin
        status        <= StatusOk;
        first_entry   <= first;
        tail_bytes    <= 6'(tail);
        entries_moved <= done;
      end
    end
  end

endmodule

[design/cbta_ctrl.sv]
module cbta_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  use_emptiest,
  input  logic                  mode,
  output logic                  busy,
  output logic                  done,
  output cbta_pkg::cbta_cmd_t   cmd,
  input  cbta_pkg::cbta_stat_t  stat
);
  import cbta_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PICK, S_CHECK, S_RD, S_WAIT, S_EVAL, S_COMMIT, S_EMIT, S_OUT
  } state_t;

  state_t state;

  assign busy = (state != S_IDLE);

  // command decode from state
  always_comb begin
    cmd           = '0;
    cmd.clr_step  = (state == S_CLEAR);
    cmd.load      = (state == S_IDLE) && start;
    cmd.pick_step = (state == S_PICK);
    cmd.rd        = (state == S_RD);
    cmd.commit    = (state == S_COMMIT);
    cmd.emit      = (state == S_EMIT);
    if (state == S_EVAL) begin
      if (stat.is_free) begin
        cmd.free_hit = !stat.rd_is_free;
      end else begin
        cmd.alloc_hit = stat.rd_is_free;
        cmd.alloc_adv = 1'b1;
      end
    end
  end

  // hold state and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      done      <= 1'b0;
    end else begin
      done <= (state == S_EMIT);
      unique case (state)
        S_CLEAR: if (stat.clr_done) state <= S_IDLE;
        S_IDLE: if (start) begin
          state     <= (use_emptiest && !mode) ? S_PICK : S_CHECK;
        end
        S_PICK: if (stat.pick_done) state <= S_CHECK;
        S_CHECK: begin
          if (stat.is_free) state <= stat.free_stop ? S_COMMIT : S_RD;
          else if (stat.too_long || stat.no_room) state <= S_EMIT;
          else state <= S_RD;
        end
        S_RD:   state <= S_WAIT;
        S_WAIT: state <= S_EVAL;
        S_EVAL: begin
          if (stat.is_free) state <= stat.rd_is_free ? S_COMMIT : S_OUT;
          else state <= S_OUT;
        end
        S_OUT: begin
          if (stat.is_free) state <= stat.free_stop ? S_COMMIT : S_RD;
          else state <= stat.alloc_done ? S_COMMIT : S_RD;
        end
        S_COMMIT: state <= S_EMIT;
        S_EMIT:   state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // the result strobe follows only the emit state
  assert property (@(posedge clk) disable iff (rst) done |-> $past(state == S_EMIT))
    else $error("result strobe without emit");
  // the clearing sweep ends before any request
  assert property (@(posedge clk) disable iff (rst) cmd.load |-> !cmd.clr_step)
    else $error("load during clearing sweep");
  // a commit is always followed by the result beat
  assert property (@(posedge clk) disable iff (rst) cmd.commit |=> cmd.emit)
    else $error("commit not followed by emit");

endmodule

[sim/chained_block_table_allocator_checker.sv]
module chained_block_table_allocator_checker
  import cbta_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic        done,
  input  logic        mode,
  input  logic [15:0] length,
  input  logic        use_emptiest,
  input  logic [1:0]  target_table,
  input  logic [7:0]  start_entry,
  input  logic [1:0]  status,
  input  logic [1:0]  table_id,
  input  logic [7:0]  first_entry,
  input  logic [5:0]  tail_bytes,
  input  logic [7:0]  entries_moved,
  input  logic [7:0]  free_left,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Tables = TableCountDefault;
  localparam int Sector = SectorBytesDefault;

  typedef struct packed {
    status_t    status;
    logic [1:0] table_id;
    logic [7:0] first_entry;
    logic [5:0] tail_bytes;
    logic [7:0] entries_moved;
    logic [7:0] free_left;
  } chain_result_t;

  logic [7:0]    link_mem [Tables][256];
  logic [7:0]    free_cnt [Tables];
  chain_result_t chain_result_q [$];

  // format the shadow tables as the block does after reset
  task automatic format_tables();
    for (int t = 0; t < Tables; t++) begin
      for (int e = 0; e < 256; e++) link_mem[t][e] = MarkFree;
      free_cnt[t] = 8'd254;
    end
    link_mem[RootTableDefault][RootEntryDefault] = MarkEnd;
    free_cnt[RootTableDefault] = 8'd253;
  endtask

  // work out one request against the shadow tables
  task automatic run_request(input logic m, input logic [15:0] len, input logic emptiest,
                             input logic [1:0] tgt, input logic [7:0] first_in,
                             output chain_result_t r);
    int tab, secs, tail, need, linked, prev, e, nxt;
    tab = tgt;
    linked = 0;
    prev = 0;
    r = '0;
    if (!m) begin
      if (emptiest) begin
        tab = 0;
        for (int t = 1; t < Tables; t++) if (free_cnt[t] > free_cnt[tab]) tab = t;
      end
      r.table_id = tab[1:0];
      secs = len / Sector;
      tail = len % Sector;
      if (secs > MaxSectors) begin
        r.status = StatusTooLong;
      end else begin
        if (tail == 0 && secs > 0) tail = Sector;
        need = secs + 1 - ((tail == Sector) ? 1 : 0);
        if (tab >= Tables || need > free_cnt[tab]) begin
          r.status = StatusNoRoom;
        end else begin
          // link the lowest free entries in ascending order
          for (e = 1; e < 255 && linked < need; e++) begin
            if (link_mem[tab][e] == MarkFree) begin
              link_mem[tab][e] = MarkEnd;
              if (linked == 0) r.first_entry = e[7:0];
              else link_mem[tab][prev] = e[7:0];
              prev = e;
              linked++;
            end
          end
          free_cnt[tab] = free_cnt[tab] - linked[7:0];
          r.status = StatusOk;
          r.tail_bytes = tail[5:0];
        end
      end
    end else begin
      r.table_id = tab[1:0];
      r.status = StatusOk;
      if (tab < Tables) begin
        // follow the chain, stop on a free or end mark
        e = first_in;
        while (e != MarkFree && e != MarkEnd && linked < 254) begin
          nxt = link_mem[tab][e];
          if (nxt == MarkFree) break;
          link_mem[tab][e] = MarkFree;
          linked++;
          e = nxt;
        end
        free_cnt[tab] = free_cnt[tab] + linked[7:0];
      end
    end
    r.entries_moved = linked[7:0];
    r.free_left = (tab < Tables) ? free_cnt[tab] : 8'd0;
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // compare the finished beat first, then predict the one taken at this edge
  always @(posedge clk) begin
    chain_result_t exp_r, new_r;
    if (rst) begin
      format_tables();
      chain_result_q.delete();
      errors = 0;
    end else begin
      if (done) begin
        if (chain_result_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual status %0d",
                   $time, status);
          errors++;
        end else begin
          exp_r = chain_result_q.pop_front();
          check_field("status", exp_r.status, status);
          check_field("table_id", exp_r.table_id, table_id);
          check_field("first_entry", exp_r.first_entry, first_entry);
          check_field("tail_bytes", exp_r.tail_bytes, tail_bytes);
          check_field("entries_moved", exp_r.entries_moved, entries_moved);
          check_field("free_left", exp_r.free_left, free_left);
        end
      end
      if (start && !busy) begin
        run_request(mode, length, use_emptiest, target_table, start_entry, new_r);
        chain_result_q.push_back(new_r);
      end
    end
    pending <= chain_result_q.size();
  end

endmodule

[sim/chained_block_table_allocator_tb.sv]
module chained_block_table_allocator_tb;
  import cbta_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 12_000_000;
  localparam int RandomBeats = 1800;

  logic        clk, rst, start, busy, done;
  logic        mode, use_emptiest;
  logic [15:0] length;
  logic [1:0]  target_table, status, table_id;
  logic [7:0]  start_entry, first_entry, entries_moved, free_left;
  logic [5:0]  tail_bytes;
  int          errors, pending, cycles;
  logic        idling;

  // chains handed out so far, kept for later frees
  logic [1:0]  live_tab [$];
  logic [7:0]  live_first [$];

  chained_block_table_allocator dut (.*);

  chained_block_table_allocator_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // send one beat, hold it until taken, then wait for its result
  task automatic send_beat(input logic m, input logic [15:0] len, input logic emp,
                           input logic [1:0] tgt, input logic [7:0] ent);
    while (idling && $urandom_range(0, 99) < 23) @(posedge clk);
    mode <= m;
    length <= len;
    use_emptiest <= emp;
    target_table <= tgt;
    start_entry <= ent;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    do @(posedge clk); while (!done);
    if (!m && status == StatusOk) begin
      live_tab.push_back(table_id);
      live_first.push_back(first_entry);
    end
  endtask

  task automatic alloc_beat(input logic [15:0] len, input logic emp, input logic [1:0] tgt);
    send_beat(1'b0, len, emp, tgt, 8'($urandom));
  endtask

  task automatic free_beat(input logic [1:0] tgt, input logic [7:0] ent);
    send_beat(1'b1, 16'($urandom), 1'($urandom), tgt, ent);
  endtask

  // free a recorded chain picked at random
  task automatic free_live();
    int k;
    k = $urandom_range(0, live_tab.size() - 1);
    free_beat(live_tab[k], live_first[k]);
    live_tab.delete(k);
    live_first.delete(k);
  endtask

  initial begin
    int pick, k;
    idling = 1'b1;
    rst <= 1'b1;
    start <= 1'b0;
    mode <= 1'b0;
    length <= '0;
    use_emptiest <= 1'b0;
    target_table <= '0;
    start_entry <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: sector split edges, limits, reserved and stale frees
    alloc_beat(16'd0, 1'b0, 2'd0);
    alloc_beat(16'd1, 1'b0, 2'd0);
    alloc_beat(16'd32, 1'b0, 2'd0);
    alloc_beat(16'd33, 1'b0, 2'd0);
    alloc_beat(16'd8159, 1'b0, 2'd2);
    alloc_beat(16'd8160, 1'b0, 2'd3);
    alloc_beat(16'hFFFF, 1'b1, 2'd0);
    alloc_beat(16'd8128, 1'b0, 2'd1);
    alloc_beat(16'd0, 1'b0, 2'd1);
    alloc_beat(16'd64, 1'b1, 2'd1);
    free_beat(2'd1, 8'd1);
    free_beat(2'd1, 8'd1);
    free_beat(2'd0, 8'd0);
    free_beat(2'd0, 8'd255);
    free_beat(2'd0, 8'd254);
    free_beat(2'd2, 8'd3);
    free_beat(2'd0, 8'd1);
    alloc_beat(16'd100, 1'b0, 2'd0);
    free_beat(2'd3, 8'd1);
    while (live_tab.size() > 0) free_live();

    // random: mostly real chains, some stray frees and wide lengths
    for (int i = 0; i < RandomBeats; i++) begin
      idling = !(i >= 600 && i < 800);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        k = $urandom_range(0, 9);
        alloc_beat(k == 0 ? 16'($urandom) : k == 1 ? 16'($urandom_range(7900, 8200))
                   : 16'($urandom_range(0, 700)), 1'($urandom), 2'($urandom));
      end else if (pick < 88 && live_tab.size() > 0) begin
        free_live();
      end else begin
        free_beat(2'($urandom), 8'($urandom));
      end
    end

    // drain, then allow for the longest walk
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
